@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_AT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`define ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`else

`define ASSERT_AT(label, clk, rstn, prop, msg)

`define ASSERT_IMPLY(label, clk, rstn, ante, cons, msg)

`endif

`endif

@@ rtl/core/slip_rx_pkg.sv @@
// ----------------------------------------------------------------------------
// SLIP receiver package
// Constants, result codes and descriptor tables for the SLIP packet receiver.
// ----------------------------------------------------------------------------
package slip_rx_pkg;

    localparam int MAX_DESC   = 8;
    localparam int DESC_IDX_W = (MAX_DESC > 1) ? $clog2(MAX_DESC) : 1;
    localparam int DESC_CNT_W = $clog2(MAX_DESC + 1);

    localparam logic [7:0] SLIP_FEND    = 8'hC0;
    localparam logic [7:0] SLIP_ESC     = 8'hDB;
    localparam logic [7:0] SLIP_ESC_END = 8'hDC;
    localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

    localparam int HDR_LEN = 6;

    localparam logic [1:0] KIND_PARAM     = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD   = 2'd1;
    localparam logic [1:0] KIND_FRAME_END = 2'd2;

    localparam logic [2:0] STAT_OK          = 3'd0;
    localparam logic [2:0] STAT_SHORT       = 3'd1;
    localparam logic [2:0] STAT_LEN_MISMATCH = 3'd2;
    localparam logic [2:0] STAT_BAD_CSUM    = 3'd3;
    localparam logic [2:0] STAT_DESC_TRUNC  = 3'd4;
    localparam logic [2:0] STAT_PARAM_TRUNC = 3'd5;
    localparam logic [2:0] STAT_DESC_OVFL   = 3'd6;

    localparam int OUT_DATA_W = 80;

    function automatic logic [2:0] desc_size(input logic [2:0] code);
        logic [2:0] s;
        case (code)
            3'd1, 3'd2, 3'd3, 3'd4: s = 3'd1;
            3'd5, 3'd6:             s = 3'd2;
            3'd7:                   s = 3'd4;
            default:                s = 3'd0;
        endcase
        return s;
    endfunction

    function automatic logic [2:0] desc_count(input logic [2:0] code);
        logic [2:0] c;
        case (code)
            3'd1, 3'd5, 3'd7: c = 3'd1;
            3'd2, 3'd6:       c = 3'd2;
            3'd3:             c = 3'd3;
            3'd4:             c = 3'd4;
            default:          c = 3'd0;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/core/slip_packet_receiver_core.sv @@
// ----------------------------------------------------------------------------
// SLIP packet receiver core
// Deframes SLIP bytes, parses header and descriptors, emits parameters,
// payload bytes and a frame-end status item.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                        | tuser
//  s_      | in  | rx_byte                      | -
//  m_      | out | value,pbytes,dev,cmd,status, | item_kind
//          |     | total_params,payload_count   |
//
// One item per cycle sustained while m_tready is high; an accepted input item
// is registered in the input register, then its result in the result register.
// Reset clears frame state (not the accumulator or descriptor memory) and hunts for the first END byte.
// m_tready low holds the result; one further item waits in the input register.
// Bytes that give no result just update state and leave the result register.
`include "assert_macros.svh"

module slip_packet_receiver_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [31:0] item_value, [34:32] param_bytes,
                                   // [42:35] device_id, [50:43] command_code,
                                   // [53:51] frame_status, [59:54] total_params,
                                   // [75:60] payload_count, [79:76] zero
    output logic [1:0]  m_tuser    // [1:0] item_kind
);

    typedef enum logic [1:0] {
        MODE_HUNT,
        MODE_FRAME,
        MODE_ESCAPE
    } rx_mode_t;

    localparam int IW = slip_rx_pkg::DESC_IDX_W;
    localparam int CW = slip_rx_pkg::DESC_CNT_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(slip_rx_pkg::MAX_DESC);

    rx_mode_t        mode_reg, mode_next;
    logic            in_valid_reg, in_valid_next;
    logic [7:0]      in_byte_reg, in_byte_next;
    logic [16:0]     dec_cnt_reg, dec_cnt_next;
    logic [7:0]      sum_reg, sum_next;
    logic [7:0]      sent_ck_reg, sent_ck_next;
    logic [15:0]     len_reg, len_next;
    logic [7:0]      dev_reg, dev_next;
    logic [7:0]      cmd_reg, cmd_next;
    logic [CW-1:0]   desc_total_reg, desc_total_next;
    logic [CW-1:0]   q_wr_reg, q_wr_next;
    logic [CW-1:0]   q_rd_reg, q_rd_next;
    logic [2:0]      cur_code_reg, cur_code_next;
    logic            chain_reg, chain_next;
    logic [2:0]      fields_left_reg, fields_left_next;
    logic [1:0]      byte_idx_reg, byte_idx_next;
    logic [31:0]     acc_reg, acc_next;
    logic [5:0]      param_cnt_reg, param_cnt_next;
    logic [15:0]     pay_cnt_reg, pay_cnt_next;
    logic            ovfl_reg, ovfl_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic [79:0]     m_tdata_reg, m_tdata_next;
    logic [1:0]      m_tuser_reg, m_tuser_next;

    logic [2:0]      desc_mem [slip_rx_pkg::MAX_DESC];
    logic            mem_we;
    logic [IW-1:0]   mem_waddr;
    logic [2:0]      mem_wdata;

    logic            advance;
    logic            work;
    logic            do_clear;
    logic            do_end;
    logic            do_take;
    logic [7:0]      db;

    logic            res_valid;
    logic [1:0]      res_kind;
    logic [31:0]     res_value;
    logic [2:0]      res_pbytes;
    logic [7:0]      res_dev;
    logic [7:0]      res_cmd;
    logic [2:0]      res_status;
    logic [5:0]      res_np;
    logic [15:0]     res_npay;

    logic [8:0]      sum_wide;
    logic [2:0]      dcode;
    logic            stored;
    logic [2:0]      head_code;
    logic [2:0]      fsize;
    logic [2:0]      idx_inc;
    logic [31:0]     acc_new;
    logic [2:0]      fl_dec;
    logic [CW-1:0]   rd_nxt;
    logic [2:0]      nxt_code;

    logic            chk_param;
    logic            chk_end;
    logic            pbytes_ok;
    logic            end_clean;
    logic            fields_busy;
    logic            desc_live;
    logic            hunting;
    logic            frame_idle;

    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign work     = in_valid_reg && advance;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // SLIP unescape
    always_comb begin
        mode_next = mode_reg;
        do_clear  = 1'b0;
        do_end    = 1'b0;
        do_take   = 1'b0;
        db        = in_byte_reg;
        if (work) begin
            case (mode_reg)
                MODE_HUNT: begin
                    if (in_byte_reg == slip_rx_pkg::SLIP_FEND) begin
                        mode_next = MODE_FRAME;
                        do_clear  = 1'b1;
                    end
                end
                MODE_ESCAPE: begin
                    mode_next = MODE_FRAME;
                    if (in_byte_reg == slip_rx_pkg::SLIP_ESC_END) begin
                        do_take = 1'b1;
                        db      = slip_rx_pkg::SLIP_FEND;
                    end else if (in_byte_reg == slip_rx_pkg::SLIP_ESC_ESC) begin
                        do_take = 1'b1;
                        db      = slip_rx_pkg::SLIP_ESC;
                    end
                end
                default: begin
                    if (in_byte_reg == slip_rx_pkg::SLIP_FEND) begin
                        do_end = 1'b1;
                    end else if (in_byte_reg == slip_rx_pkg::SLIP_ESC) begin
                        mode_next = MODE_ESCAPE;
                    end else begin
                        mode_next = MODE_FRAME;
                        do_take   = 1'b1;
                    end
                end
            endcase
        end
    end

    // Packet parse
    always_comb begin
        dec_cnt_next     = dec_cnt_reg;
        sum_next         = sum_reg;
        sent_ck_next     = sent_ck_reg;
        len_next         = len_reg;
        dev_next         = dev_reg;
        cmd_next         = cmd_reg;
        desc_total_next  = desc_total_reg;
        q_wr_next        = q_wr_reg;
        q_rd_next        = q_rd_reg;
        cur_code_next    = cur_code_reg;
        chain_next       = chain_reg;
        fields_left_next = fields_left_reg;
        byte_idx_next    = byte_idx_reg;
        acc_next         = acc_reg;
        param_cnt_next   = param_cnt_reg;
        pay_cnt_next     = pay_cnt_reg;
        ovfl_next        = ovfl_reg;
        mem_we           = 1'b0;
        mem_waddr        = q_wr_reg[IW-1:0];
        dcode            = db[2:0];
        mem_wdata        = dcode;
        res_valid        = 1'b0;
        res_kind         = slip_rx_pkg::KIND_PAYLOAD;
        res_value        = 32'd0;
        res_pbytes       = 3'd0;
        res_dev          = 8'd0;
        res_cmd          = 8'd0;
        res_status       = slip_rx_pkg::STAT_OK;
        res_np           = 6'd0;
        res_npay         = 16'd0;
        sum_wide         = {1'b0, sum_reg} + {1'b0, db};
        stored           = 1'b0;
        head_code        = (q_wr_reg == '0) ? dcode : desc_mem[0];
        fsize            = slip_rx_pkg::desc_size(cur_code_reg);
        idx_inc          = {1'b0, byte_idx_reg} + 3'd1;
        fl_dec           = fields_left_reg - 3'd1;
        rd_nxt           = q_rd_reg + CW'(1);
        nxt_code         = desc_mem[rd_nxt[IW-1:0]];
        acc_new          = acc_reg;
        case (byte_idx_reg)
            2'd0:    acc_new[7:0]   = acc_reg[7:0]   | db;
            2'd1:    acc_new[15:8]  = acc_reg[15:8]  | db;
            2'd2:    acc_new[23:16] = acc_reg[23:16] | db;
            default: acc_new[31:24] = acc_reg[31:24] | db;
        endcase

        if (do_end && dec_cnt_reg != 17'd0) begin
            res_valid = 1'b1;
            res_kind  = slip_rx_pkg::KIND_FRAME_END;
            res_dev   = dev_reg;
            res_cmd   = cmd_reg;
            res_np    = param_cnt_reg;
            res_npay  = pay_cnt_reg;
            if (dec_cnt_reg < 17'(slip_rx_pkg::HDR_LEN)) begin
                res_status = slip_rx_pkg::STAT_SHORT;
            end else if ({1'b0, len_reg} != dec_cnt_reg) begin
                res_status = slip_rx_pkg::STAT_LEN_MISMATCH;
            end else if (sum_reg != sent_ck_reg) begin
                res_status = slip_rx_pkg::STAT_BAD_CSUM;
            end else if (ovfl_reg) begin
                res_status = slip_rx_pkg::STAT_DESC_OVFL;
            end else if (chain_reg) begin
                res_status = slip_rx_pkg::STAT_DESC_TRUNC;
            end else if (fields_left_reg != 3'd0) begin
                res_status = slip_rx_pkg::STAT_PARAM_TRUNC;
            end
        end

        if (do_clear || do_end) begin
            dec_cnt_next     = '0;
            sum_next         = '0;
            sent_ck_next     = '0;
            len_next         = '0;
            dev_next         = '0;
            cmd_next         = '0;
            desc_total_next  = '0;
            q_wr_next        = '0;
            q_rd_next        = '0;
            cur_code_next    = '0;
            chain_next       = 1'b0;
            fields_left_next = '0;
            byte_idx_next    = '0;
            acc_next         = '0;
            param_cnt_next   = '0;
            pay_cnt_next     = '0;
            ovfl_next        = 1'b0;
        end else if (do_take) begin
            if (dec_cnt_reg != 17'h1FFFF) begin
                dec_cnt_next = dec_cnt_reg + 17'd1;
            end
            if (dec_cnt_reg != 17'd4) begin
                sum_next = sum_wide[8] ? (sum_wide[7:0] + 8'd1) : sum_wide[7:0];
            end

            if (dec_cnt_reg == 17'd0) begin
                dev_next = db;
            end else if (dec_cnt_reg == 17'd1) begin
                cmd_next = db;
            end else if (dec_cnt_reg == 17'd2) begin
                len_next = {8'd0, db};
            end else if (dec_cnt_reg == 17'd3) begin
                len_next = {db, len_reg[7:0]};
            end else if (dec_cnt_reg == 17'd4) begin
                sent_ck_next = db;
            end else if (dec_cnt_reg == 17'd5 || chain_reg) begin
                if (desc_total_reg < MAX_CNT) begin
                    desc_total_next = desc_total_reg + CW'(1);
                    if (dcode != 3'd0) begin
                        mem_we    = 1'b1;
                        q_wr_next = q_wr_reg + CW'(1);
                        stored    = 1'b1;
                    end
                end else begin
                    ovfl_next = 1'b1;
                end
                chain_next = db[7];
                if (!db[7]) begin
                    q_rd_next     = '0;
                    byte_idx_next = '0;
                    acc_next      = '0;
                    if (q_wr_reg != '0 || stored) begin
                        cur_code_next    = head_code;
                        fields_left_next = slip_rx_pkg::desc_count(head_code);
                    end else begin
                        fields_left_next = '0;
                    end
                end
            end else if (fields_left_reg != 3'd0) begin
                if (idx_inc >= fsize) begin
                    res_valid     = 1'b1;
                    res_kind      = slip_rx_pkg::KIND_PARAM;
                    res_value     = acc_new;
                    res_pbytes    = fsize;
                    if (param_cnt_reg != 6'd63) begin
                        param_cnt_next = param_cnt_reg + 6'd1;
                    end
                    byte_idx_next    = '0;
                    acc_next         = '0;
                    fields_left_next = fl_dec;
                    if (fl_dec == 3'd0) begin
                        q_rd_next = rd_nxt;
                        if (rd_nxt < q_wr_reg) begin
                            cur_code_next    = nxt_code;
                            fields_left_next = slip_rx_pkg::desc_count(nxt_code);
                        end
                    end
                end else begin
                    byte_idx_next = idx_inc[1:0];
                    acc_next      = acc_new;
                end
            end else begin
                res_valid = 1'b1;
                res_kind  = slip_rx_pkg::KIND_PAYLOAD;
                res_value = {24'd0, db};
                if (pay_cnt_reg != 16'hFFFF) begin
                    pay_cnt_next = pay_cnt_reg + 16'd1;
                end
            end
        end
    end

    // Handshake and result register
    always_comb begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_tdata;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        if (advance) begin
            m_tvalid_next = work && res_valid;
            if (work && res_valid) begin
                m_tdata_next = {4'd0, res_npay, res_np, res_status, res_cmd, res_dev,
                                res_pbytes, res_value};
                m_tuser_next = res_kind;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            desc_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg  <= in_byte_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
        acc_reg      <= acc_next;
        if (!aresetn) begin
            mode_reg        <= MODE_HUNT;
            in_valid_reg    <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            dec_cnt_reg     <= '0;
            sum_reg         <= '0;
            sent_ck_reg     <= '0;
            len_reg         <= '0;
            dev_reg         <= '0;
            cmd_reg         <= '0;
            desc_total_reg  <= '0;
            q_wr_reg        <= '0;
            q_rd_reg        <= '0;
            cur_code_reg    <= '0;
            chain_reg       <= 1'b0;
            fields_left_reg <= '0;
            byte_idx_reg    <= '0;
            param_cnt_reg   <= '0;
            pay_cnt_reg     <= '0;
            ovfl_reg        <= 1'b0;
        end else begin
            mode_reg        <= mode_next;
            in_valid_reg    <= in_valid_next;
            m_tvalid_reg    <= m_tvalid_next;
            dec_cnt_reg     <= dec_cnt_next;
            sum_reg         <= sum_next;
            sent_ck_reg     <= sent_ck_next;
            len_reg         <= len_next;
            dev_reg         <= dev_next;
            cmd_reg         <= cmd_next;
            desc_total_reg  <= desc_total_next;
            q_wr_reg        <= q_wr_next;
            q_rd_reg        <= q_rd_next;
            cur_code_reg    <= cur_code_next;
            chain_reg       <= chain_next;
            fields_left_reg <= fields_left_next;
            byte_idx_reg    <= byte_idx_next;
            param_cnt_reg   <= param_cnt_next;
            pay_cnt_reg     <= pay_cnt_next;
            ovfl_reg        <= ovfl_next;
        end
    end

    assign chk_param   = m_tvalid_reg && (m_tuser_reg == slip_rx_pkg::KIND_PARAM);
    assign chk_end     = m_tvalid_reg && (m_tuser_reg == slip_rx_pkg::KIND_FRAME_END);
    assign pbytes_ok   = (m_tdata_reg[34:32] == 3'd1) || (m_tdata_reg[34:32] == 3'd2) ||
                         (m_tdata_reg[34:32] == 3'd4);
    assign end_clean   = (m_tdata_reg[34:0] == 35'd0);
    assign fields_busy = (fields_left_reg != 3'd0);
    assign desc_live   = !chain_reg && (q_rd_reg < q_wr_reg) && (cur_code_reg != 3'd0);
    assign hunting     = (mode_reg == MODE_HUNT);
    assign frame_idle  = (dec_cnt_reg == 17'd0) && (param_cnt_reg == 6'd0);

    `ASSERT_IMPLY(a_param_width, aclk, aresetn, chk_param, pbytes_ok, "illegal parameter width")
    `ASSERT_IMPLY(a_end_clean, aclk, aresetn, chk_end, end_clean, "frame end item carries value")
    `ASSERT_IMPLY(a_field_desc, aclk, aresetn, fields_busy, desc_live, "orphan field parse")
    `ASSERT_AT(a_queue_bound, aclk, aresetn, q_wr_reg <= desc_total_reg, "descriptor queue overrun")
    `ASSERT_IMPLY(a_hunt_clear, aclk, aresetn, hunting, frame_idle, "frame state while hunting")

endmodule
